// ===== design/tbet_pkg.sv =====
package tbet_pkg;

    localparam int POS_W     = 16;
    localparam int TIME_W    = 32;
    localparam int BUTTON_W  = 4;
    localparam int MODE_W    = 3;
    localparam int MASK_W    = 4;
    localparam int DZ_W      = 15;
    localparam int ORIENT_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int SIGN_W    = 2;

    localparam logic [MODE_W-1:0] MODE_FRAME_START = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TOUCH_DOWN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOUCH_MOVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TOUCH_UP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BUTTON_DOWN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BUTTON_UP   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 1'b1;

    localparam logic [ORIENT_W-1:0] ORIENT_RIGHT  = 2'd0;
    localparam logic [ORIENT_W-1:0] ORIENT_TOP    = 2'd1;
    localparam logic [ORIENT_W-1:0] ORIENT_BOTTOM = 2'd2;
    localparam logic [ORIENT_W-1:0] ORIENT_LEFT   = 2'd3;

    localparam int BTN_UP   = 1;
    localparam int BTN_DOWN = 3;

    localparam logic [ORIENT_W-1:0] ORIENT_RESET = ORIENT_RIGHT;
    localparam logic [DZ_W-1:0]     DZ_RESET     = 15'd8;

    localparam logic signed [SIGN_W-1:0] SIGN_NONE = 2'sb00;
    localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [SIGN_W-1:0] SIGN_NEG  = 2'sb11;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_y;
        logic [BUTTON_W-1:0]        button;
        logic [TIME_W-1:0]          time_ms;
    } event_t;

    typedef struct packed {
        logic [MASK_W-1:0]          held_mask;
        logic [MASK_W-1:0]          pressed_mask;
        logic [MASK_W-1:0]          released_mask;
        logic                       touch_active;
        logic                       touch_tap;
        logic signed [POS_W-1:0]    touch_x;
        logic signed [POS_W-1:0]    touch_y;
        logic signed [SIGN_W-1:0]   drag_x;
        logic signed [SIGN_W-1:0]   drag_y;
        logic signed [SIGN_W-1:0]   axis_held;
        logic signed [SIGN_W-1:0]   axis_pressed;
        logic [TIME_W-1:0]          held_time;
    } result_t;

endpackage

// ===== design/tbet_core.sv =====
module tbet_core #(
    parameter int BUTTON_COUNT = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tbet_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbet_pkg::DZ_W-1:0]         cfg_data,
    input  logic                              step,
    input  tbet_pkg::event_t                  item,
    output tbet_pkg::result_t                 result
);

    logic [tbet_pkg::ORIENT_W-1:0]        orient_reg;
    logic [tbet_pkg::DZ_W-1:0]            dz_reg;

    logic [BUTTON_COUNT-1:0]              held_reg,     held_next;
    logic [BUTTON_COUNT-1:0]              pressed_reg,  pressed_next;
    logic [BUTTON_COUNT-1:0]              released_reg, released_next;
    logic [tbet_pkg::TIME_W-1:0]          stamp_reg  [BUTTON_COUNT];
    logic [tbet_pkg::TIME_W-1:0]          stamp_next [BUTTON_COUNT];

    logic                                 down_reg, down_next;
    logic                                 tap_reg,  tap_next;
    logic signed [tbet_pkg::POS_W-1:0]    origin_x_reg, origin_x_next;
    logic signed [tbet_pkg::POS_W-1:0]    origin_y_reg, origin_y_next;
    logic signed [tbet_pkg::POS_W-1:0]    last_x_reg,   last_x_next;
    logic signed [tbet_pkg::POS_W-1:0]    last_y_reg,   last_y_next;
    logic signed [tbet_pkg::SIGN_W-1:0]   drag_x_reg,   drag_x_next;
    logic signed [tbet_pkg::SIGN_W-1:0]   drag_y_reg,   drag_y_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg <= tbet_pkg::ORIENT_RESET;
            dz_reg     <= tbet_pkg::DZ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbet_pkg::CFG_ORIENTATION: orient_reg <= cfg_data[tbet_pkg::ORIENT_W-1:0];
                tbet_pkg::CFG_DEAD_ZONE:   dz_reg     <= cfg_data;
                default:                   orient_reg <= orient_reg;
            endcase
        end
    end

    // Button flags and press stamps.
    always_comb
    begin
        held_next     = held_reg;
        pressed_next  = pressed_reg;
        released_next = released_reg;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            stamp_next[i] = stamp_reg[i];
        end
        if (item.mode == tbet_pkg::MODE_FRAME_START)
        begin
            pressed_next  = '0;
            released_next = '0;
        end
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            if (item.button == tbet_pkg::BUTTON_W'(i))
            begin
                if (item.mode == tbet_pkg::MODE_BUTTON_DOWN)
                begin
                    if (!held_reg[i])
                    begin
                        stamp_next[i] = item.time_ms;
                    end
                    held_next[i]    = 1'b1;
                    pressed_next[i] = 1'b1;
                end
                else if (item.mode == tbet_pkg::MODE_BUTTON_UP)
                begin
                    held_next[i]     = 1'b0;
                    released_next[i] = 1'b1;
                    stamp_next[i]    = '0;
                end
            end
        end
    end

    // Touch tracking and drag detection.
    always_comb
    begin
        logic signed [tbet_pkg::POS_W-1:0] dx;
        logic signed [tbet_pkg::POS_W-1:0] dy;
        logic signed [tbet_pkg::POS_W-1:0] rx;
        logic signed [tbet_pkg::POS_W-1:0] ry;
        logic signed [tbet_pkg::POS_W-1:0] ax;
        logic signed [tbet_pkg::POS_W-1:0] ay;
        logic signed [tbet_pkg::POS_W-1:0] dz;
        logic signed [tbet_pkg::SIGN_W-1:0] sx;
        logic signed [tbet_pkg::SIGN_W-1:0] sy;

        down_next     = down_reg;
        tap_next      = tap_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        last_x_next   = last_x_reg;
        last_y_next   = last_y_reg;
        drag_x_next   = drag_x_reg;
        drag_y_next   = drag_y_reg;

        dx = item.pos_x - origin_x_reg;
        dy = item.pos_y - origin_y_reg;
        case (orient_reg)
            tbet_pkg::ORIENT_TOP:
            begin
                rx = dy;
                ry = -dx;
            end
            tbet_pkg::ORIENT_BOTTOM:
            begin
                rx = -dy;
                ry = dx;
            end
            tbet_pkg::ORIENT_LEFT:
            begin
                rx = -dx;
                ry = -dy;
            end
            default:
            begin
                rx = dx;
                ry = dy;
            end
        endcase
        ax = rx[tbet_pkg::POS_W-1] ? -rx : rx;
        ay = ry[tbet_pkg::POS_W-1] ? -ry : ry;
        dz = signed'({1'b0, dz_reg});

        if (ax < dz && ay < dz)
        begin
            sx = tbet_pkg::SIGN_NONE;
            sy = tbet_pkg::SIGN_NONE;
        end
        else if (ax > ay)
        begin
            sx = (rx > 16'sd0) ? tbet_pkg::SIGN_POS : tbet_pkg::SIGN_NEG;
            sy = tbet_pkg::SIGN_NONE;
        end
        else
        begin
            sx = tbet_pkg::SIGN_NONE;
            sy = (ry > 16'sd0) ? tbet_pkg::SIGN_POS : tbet_pkg::SIGN_NEG;
        end

        if (!down_reg && item.mode == tbet_pkg::MODE_TOUCH_DOWN)
        begin
            down_next     = 1'b1;
            origin_x_next = item.pos_x;
            origin_y_next = item.pos_y;
            last_x_next   = item.pos_x;
            last_y_next   = item.pos_y;
            drag_x_next   = tbet_pkg::SIGN_NONE;
            drag_y_next   = tbet_pkg::SIGN_NONE;
        end
        else if (down_reg && (item.mode == tbet_pkg::MODE_TOUCH_MOVE
                              || item.mode == tbet_pkg::MODE_TOUCH_UP))
        begin
            last_x_next = item.pos_x;
            last_y_next = item.pos_y;
            drag_x_next = sx;
            drag_y_next = sy;
            if (item.mode == tbet_pkg::MODE_TOUCH_UP)
            begin
                if (sx == tbet_pkg::SIGN_NONE && sy == tbet_pkg::SIGN_NONE)
                begin
                    tap_next = 1'b1;
                end
                down_next   = 1'b0;
                drag_x_next = tbet_pkg::SIGN_NONE;
                drag_y_next = tbet_pkg::SIGN_NONE;
            end
        end
        else if (item.mode == tbet_pkg::MODE_FRAME_START)
        begin
            tap_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            pressed_reg  <= '0;
            released_reg <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                stamp_reg[i] <= '0;
            end
            down_reg     <= 1'b0;
            tap_reg      <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
            drag_x_reg   <= tbet_pkg::SIGN_NONE;
            drag_y_reg   <= tbet_pkg::SIGN_NONE;
        end
        else if (step)
        begin
            held_reg     <= held_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                stamp_reg[i] <= stamp_next[i];
            end
            down_reg     <= down_next;
            tap_reg      <= tap_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            last_x_reg   <= last_x_next;
            last_y_reg   <= last_y_next;
            drag_x_reg   <= drag_x_next;
            drag_y_reg   <= drag_y_next;
        end
    end

    // The result shows the state as it stands after the item.
    always_comb
    begin
        logic                          sel_held;
        logic [tbet_pkg::TIME_W-1:0]   sel_stamp;
        logic                          near_held;
        logic                          far_held;
        logic                          near_pressed;
        logic                          far_pressed;

        sel_held  = 1'b0;
        sel_stamp = '0;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            if (item.button == tbet_pkg::BUTTON_W'(i))
            begin
                sel_held  = held_next[i];
                sel_stamp = stamp_next[i];
            end
        end

        if (orient_reg < tbet_pkg::ORIENT_BOTTOM)
        begin
            near_held    = held_next[tbet_pkg::BTN_UP];
            far_held     = held_next[tbet_pkg::BTN_DOWN];
            near_pressed = pressed_next[tbet_pkg::BTN_UP];
            far_pressed  = pressed_next[tbet_pkg::BTN_DOWN];
        end
        else
        begin
            near_held    = held_next[tbet_pkg::BTN_DOWN];
            far_held     = held_next[tbet_pkg::BTN_UP];
            near_pressed = pressed_next[tbet_pkg::BTN_DOWN];
            far_pressed  = pressed_next[tbet_pkg::BTN_UP];
        end

        result.held_mask     = held_next[tbet_pkg::MASK_W-1:0];
        result.pressed_mask  = pressed_next[tbet_pkg::MASK_W-1:0];
        result.released_mask = released_next[tbet_pkg::MASK_W-1:0];
        result.touch_active  = down_next;
        result.touch_tap     = tap_next;
        result.touch_x       = last_x_next;
        result.touch_y       = last_y_next;
        result.drag_x        = drag_x_next;
        result.drag_y        = drag_y_next;
        result.axis_held     = signed'({1'b0, far_held} - {1'b0, near_held});
        result.axis_pressed  = signed'({1'b0, far_pressed} - {1'b0, near_pressed});
        result.held_time     = sel_held ? (item.time_ms - sel_stamp) : '0;
    end

endmodule

// ===== design/touch_and_button_event_tracker.sv =====
// Touch and button event tracker. Each accepted input transaction is one event (the
// mode in s_tuser) and produces exactly one output transaction with the button
// masks, touch position, drag signs, cluster axis and held time as they stand
// after that event. The block takes one event per clock cycle while the output is
// not stalled: an event sits in the input register while the tracker logic computes
// the new state and the result, which is loaded into the output register, so
// back-pressure on the output stalls the input only when both registers are full.
// Configuration writes are accepted in every cycle and must
// be issued only while no event is in flight.
module touch_and_button_event_tracker #(
    parameter int BUTTON_COUNT = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbet_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbet_pkg::DZ_W-1:0]         cfg_data,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [71:0]                       s_tdata,   // pos_x, pos_y, button, time_ms
    input  logic [2:0]                        s_tuser,   // mode

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // held_mask, pressed_mask, released_mask, touch_active, touch_tap, touch_x,
    // touch_y, drag_x, drag_y, axis_held, axis_pressed, held_time
    output logic [87:0]                       m_tdata
);

    logic                in_valid_reg, in_valid_next;
    tbet_pkg::event_t    in_item_reg;
    logic                out_valid_reg, out_valid_next;
    tbet_pkg::result_t   out_res_reg;
    tbet_pkg::result_t   core_res;
    logic                out_load;
    logic                in_take;

    assign cfg_ready = 1'b1;
    assign out_load  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || out_load;
    assign in_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.mode    <= s_tuser;
            in_item_reg.pos_x   <= signed'(s_tdata[15:0]);
            in_item_reg.pos_y   <= signed'(s_tdata[31:16]);
            in_item_reg.button  <= s_tdata[35:32];
            in_item_reg.time_ms <= s_tdata[67:36];
        end
        if (out_load)
        begin
            out_res_reg <= core_res;
        end
    end

    tbet_core #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (out_load),
        .item      (in_item_reg),
        .result    (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_res_reg.held_time,
                       out_res_reg.axis_pressed,
                       out_res_reg.axis_held,
                       out_res_reg.drag_y,
                       out_res_reg.drag_x,
                       out_res_reg.touch_y,
                       out_res_reg.touch_x,
                       out_res_reg.touch_tap,
                       out_res_reg.touch_active,
                       out_res_reg.released_mask,
                       out_res_reg.pressed_mask,
                       out_res_reg.held_mask};

endmodule
